/* rtl/core/ils_pkg.sv */
// Package for the indexed list store: sizes, action and status codes,
// and the command/status structs between controller and datapath.
// No dependencies.
package ils_pkg;

    localparam int CAPACITY = 64;          // must be a multiple of GROUP
    localparam int CNT_W    = 7;           // width of position and length fields
    localparam int DATA_W   = 32;
    localparam int ACT_W    = 3;
    localparam int ST_W     = 2;
    localparam int GROUP    = 8;           // cells per first-level read OR
    localparam int NGROUP   = CAPACITY / GROUP;

    localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_HEAD   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TAIL   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_AT     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic            take_req;   // latch the input beat
        logic            ins_en;     // shift up and write at insert position
        logic            del_en;     // shift down from delete position
        logic            grp_cap;    // capture first-level read ORs
        logic            out_load;   // load result registers
        logic            read_ok;    // result carries the value read
        logic [ST_W-1:0] st;         // status code for the result
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             pos_lt_cnt;
        logic             pos_le_cnt;
        logic             full;
    } stat_t;

endpackage

/* rtl/core/indexed_list_store.sv */
// Top level of the indexed list store: controller and datapath.
// Depends on ils_pkg, ils_controller and ils_datapath.
//
// Keeps an ordered list of up to 64 signed 32-bit entries, packed by
// position. Each input beat on the s_ channel carries an action (read,
// insert at head, insert at tail, insert before an index, delete), a
// position and a value. Each beat produces exactly one result beat on the
// m_ channel: the value read (all ones when nothing was read), a status
// (done, out of range, full) and the length after the action.
// Inserts and deletes shift every later cell by one place, all together in the execute step.
// A read goes through a two-level registered select-and-OR over the cells.
// The controller handles one item at a time (latch, execute, gather), so no new
// beat is taken until the last one has been gathered. The result register lets the
// next beat be taken while an earlier result still waits; a stalled receiver
// holds the block in its gather step once a second result is ready.
// Reset empties the list and drops any pending result; no clearing pass.
module indexed_list_store (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ils_pkg::ACT_W-1:0]           s_action,
    input  logic [ils_pkg::CNT_W-1:0]           s_position,
    input  logic signed [ils_pkg::DATA_W-1:0]   s_item_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ils_pkg::DATA_W-1:0]   m_read_value,
    output logic [ils_pkg::ST_W-1:0]            m_status,
    output logic [ils_pkg::CNT_W-1:0]           m_length_now
);

    ils_pkg::cmd_t  cmd;
    ils_pkg::stat_t stat;

    ils_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ils_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_action     (s_action),
        .s_position   (s_position),
        .s_item_value (s_item_value),
        .cmd          (cmd),
        .stat         (stat),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_length_now (m_length_now)
    );

endmodule

/* rtl/core/ils_datapath.sv */
// Datapath of the indexed list store: request latch, row of shifting cells,
// entry count, two-level registered read gather and result registers.
// Depends on ils_pkg.
module ils_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [ils_pkg::ACT_W-1:0]           s_action,
    input  logic [ils_pkg::CNT_W-1:0]           s_position,
    input  logic signed [ils_pkg::DATA_W-1:0]   s_item_value,
    input  ils_pkg::cmd_t                       cmd,
    output ils_pkg::stat_t                      stat,
    output logic signed [ils_pkg::DATA_W-1:0]   m_read_value,
    output logic [ils_pkg::ST_W-1:0]            m_status,
    output logic [ils_pkg::CNT_W-1:0]           m_length_now
);

    logic [ils_pkg::ACT_W-1:0]  req_act_reg;
    logic [ils_pkg::CNT_W-1:0]  req_pos_reg;
    logic [ils_pkg::DATA_W-1:0] req_val_reg;
    logic [ils_pkg::CNT_W-1:0]  count_reg;
    logic [ils_pkg::CNT_W-1:0]  count_next;
    logic [ils_pkg::CNT_W-1:0]  ins_pos;

    logic [ils_pkg::DATA_W-1:0] cell_reg [ils_pkg::CAPACITY];
    logic [ils_pkg::DATA_W-1:0] grp_reg  [ils_pkg::NGROUP];
    logic [ils_pkg::DATA_W-1:0] grp_next [ils_pkg::NGROUP];
    logic [ils_pkg::DATA_W-1:0] gather;

    logic [ils_pkg::DATA_W-1:0] rv_reg;
    logic [ils_pkg::ST_W-1:0]   st_reg;
    logic [ils_pkg::CNT_W-1:0]  len_reg;

    always_ff @(posedge aclk) begin
        if (cmd.take_req) begin
            req_act_reg <= s_action;
            req_pos_reg <= s_position;
            req_val_reg <= s_item_value;
        end
    end

    always_comb begin
        case (req_act_reg)
            ils_pkg::ACT_HEAD: ins_pos = '0;
            ils_pkg::ACT_TAIL: ins_pos = count_reg;
            default:           ins_pos = req_pos_reg;
        endcase
    end

    assign stat.act        = req_act_reg;
    assign stat.pos_lt_cnt = req_pos_reg < count_reg;
    assign stat.pos_le_cnt = req_pos_reg <= count_reg;
    assign stat.full       = count_reg == ils_pkg::CNT_W'(ils_pkg::CAPACITY);

    always_comb begin
        count_next = count_reg;
        if (cmd.ins_en) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.del_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // each cell looks only at its neighbours
    for (genvar i = 0; i < ils_pkg::CAPACITY; i++) begin : g_cell
        localparam int BELOW = (i == 0) ? 0 : i - 1;
        localparam int ABOVE = (i == ils_pkg::CAPACITY - 1) ? i : i + 1;
        localparam logic [ils_pkg::CNT_W-1:0] IDX = ils_pkg::CNT_W'(i);

        always_ff @(posedge aclk) begin
            if (cmd.ins_en) begin
                if (IDX == ins_pos) begin
                    cell_reg[i] <= req_val_reg;
                end else if (IDX > ins_pos) begin
                    cell_reg[i] <= cell_reg[BELOW];
                end
            end else if (cmd.del_en) begin
                if (IDX >= req_pos_reg) begin
                    cell_reg[i] <= cell_reg[ABOVE];
                end
            end
        end
    end

    // read gather: select-and-OR inside each group, then across groups
    always_comb begin
        for (int g = 0; g < ils_pkg::NGROUP; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < ils_pkg::GROUP; k++) begin
                if (req_pos_reg == ils_pkg::CNT_W'(g * ils_pkg::GROUP + k)) begin
                    grp_next[g] = grp_next[g] | cell_reg[g * ils_pkg::GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.grp_cap) begin
            for (int g = 0; g < ils_pkg::NGROUP; g++) begin
                grp_reg[g] <= grp_next[g];
            end
        end
    end

    always_comb begin
        gather = '0;
        for (int g = 0; g < ils_pkg::NGROUP; g++) begin
            gather = gather | grp_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            rv_reg  <= cmd.read_ok ? gather : '1;
            st_reg  <= cmd.st;
            len_reg <= count_reg;
        end
    end

    assign m_read_value = rv_reg;
    assign m_status     = st_reg;
    assign m_length_now = len_reg;

endmodule

/* rtl/core/ils_controller.sv */
// Controller of the indexed list store: decides each action's outcome,
// sequences the datapath and owns both handshakes.
// Depends on ils_pkg.
module ils_controller (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  ils_pkg::stat_t  stat,
    output ils_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_GATHER = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     read_ok_reg, read_ok_next;
    logic [ils_pkg::ST_W-1:0] st_reg, st_next;
    logic                     do_ins, do_del, do_read;
    logic [ils_pkg::ST_W-1:0] outcome;
    logic                     out_free;

    assign out_free = !m_valid_reg || m_ready;

    // outcome of the latched request against the current count
    always_comb begin
        do_ins  = 1'b0;
        do_del  = 1'b0;
        do_read = 1'b0;
        outcome = ils_pkg::ST_RANGE;
        case (stat.act)
            ils_pkg::ACT_READ: begin
                if (stat.pos_lt_cnt) begin
                    do_read = 1'b1;
                    outcome = ils_pkg::ST_DONE;
                end
            end
            ils_pkg::ACT_HEAD, ils_pkg::ACT_TAIL: begin
                if (stat.full) begin
                    outcome = ils_pkg::ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    outcome = ils_pkg::ST_DONE;
                end
            end
            ils_pkg::ACT_AT: begin
                if (!stat.pos_le_cnt) begin
                    outcome = ils_pkg::ST_RANGE;
                end else if (stat.full) begin
                    outcome = ils_pkg::ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    outcome = ils_pkg::ST_DONE;
                end
            end
            ils_pkg::ACT_DELETE: begin
                if (stat.pos_lt_cnt) begin
                    do_del  = 1'b1;
                    outcome = ils_pkg::ST_DONE;
                end
            end
            default: outcome = ils_pkg::ST_RANGE;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        read_ok_next = read_ok_reg;
        st_next      = st_reg;
        cmd          = '0;
        cmd.read_ok  = read_ok_reg;
        cmd.st       = st_reg;
        case (state_reg)
            S_IDLE: begin
                cmd.take_req = s_valid;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.ins_en   = do_ins;
                cmd.del_en   = do_del;
                cmd.grp_cap  = 1'b1;
                read_ok_next = do_read;
                st_next      = outcome;
                state_next   = S_GATHER;
            end
            S_GATHER: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        read_ok_reg <= read_ok_next;
        st_reg      <= st_next;
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == S_EXEC)
        else $error("accepted beat did not move to execute");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    a_one_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.ins_en && cmd.del_en))
        else $error("insert and delete in the same cycle");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("loaded result not presented");

    a_shift_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ins_en || cmd.del_en) |-> state_reg == S_EXEC)
        else $error("cells shifted outside execute");

endmodule

/* dv/indexed_list_store_test.sv */
// Self-checking testbench for indexed_list_store: a directed table, then ~1000 random beats.
// Results are predicted by an in-bench model of the list and checked field by field.
// Depends on ils_pkg and the indexed_list_store RTL.
module indexed_list_store_test;
    import ils_pkg::*;

    localparam logic [ACT_W-1:0]  ACT_RSVD5   = 3'd5;
    localparam logic [ACT_W-1:0]  ACT_RSVD6   = 3'd6;
    localparam logic [ACT_W-1:0]  ACT_RSVD7   = 3'd7;
    localparam logic [DATA_W-1:0] NO_VALUE    = '1;
    localparam int                N_DIRECTED  = 25;
    localparam int                N_PHASES    = 10;
    localparam int                PHASE_ITEMS = 100;
    localparam int                CYCLE_LIMIT = 800000;

    typedef struct packed {
        logic [DATA_W-1:0] rv;
        logic [ST_W-1:0]   st;
        logic [CNT_W-1:0]  len;
    } list_result_t;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [CNT_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        logic              typed;
        list_result_t      res;
    } step_row_t;

    typedef enum {PH_FILL, PH_MIXED, PH_DRAIN} phase_kind_t;

    logic                      aclk;
    logic                      aresetn      = 1'b0;
    logic                      s_valid      = 1'b0;
    logic                      s_ready;
    logic [ACT_W-1:0]          s_action     = ACT_READ;
    logic [CNT_W-1:0]          s_position   = '0;
    logic signed [DATA_W-1:0]  s_item_value = '0;
    logic                      m_valid;
    logic                      m_ready      = 1'b1;
    logic signed [DATA_W-1:0]  m_read_value;
    logic [ST_W-1:0]           m_status;
    logic [CNT_W-1:0]          m_length_now;

    // predictor state
    logic [DATA_W-1:0] list_mem [CAPACITY];
    int                list_len = 0;

    list_result_t pending [$];
    int           mismatches = 0;
    int           n_items    = 0;
    int           n_checked  = 0;
    int           n_full     = 0;
    int           n_range    = 0;
    int           cycles     = 0;
    bit           steady     = 1'b0;   // no idling on either side while set
    int           ready_hold = 0;

    // expected result typed in only where it is obvious
    step_row_t directed_rows [N_DIRECTED] = '{
        '{ACT_READ,   7'd0,   32'h0000_0000, 1'b1, '{NO_VALUE, ST_RANGE, 7'd0}},
        '{ACT_DELETE, 7'd0,   32'h0000_0000, 1'b1, '{NO_VALUE, ST_RANGE, 7'd0}},
        '{ACT_AT,     7'd1,   32'h0000_0005, 1'b1, '{NO_VALUE, ST_RANGE, 7'd0}},
        '{ACT_HEAD,   7'd0,   32'h8000_0000, 1'b1, '{NO_VALUE, ST_DONE,  7'd1}},
        '{ACT_TAIL,   7'd127, 32'h7FFF_FFFF, 1'b1, '{NO_VALUE, ST_DONE,  7'd2}},
        '{ACT_AT,     7'd1,   32'h0000_0000, 1'b1, '{NO_VALUE, ST_DONE,  7'd3}},
        '{ACT_AT,     7'd3,   32'hFFFF_FFFF, 1'b1, '{NO_VALUE, ST_DONE,  7'd4}},
        '{ACT_AT,     7'd0,   32'h5555_5555, 1'b1, '{NO_VALUE, ST_DONE,  7'd5}},
        '{ACT_READ,   7'd0,   32'h0000_0000, 1'b0, '0},
        '{ACT_READ,   7'd1,   32'h0000_0000, 1'b0, '0},
        '{ACT_READ,   7'd2,   32'h0000_0000, 1'b0, '0},
        '{ACT_READ,   7'd3,   32'h0000_0000, 1'b0, '0},
        '{ACT_READ,   7'd4,   32'h0000_0000, 1'b0, '0},
        '{ACT_READ,   7'd5,   32'h0000_0000, 1'b1, '{NO_VALUE, ST_RANGE, 7'd5}},
        '{ACT_READ,   7'd127, 32'hFFFF_FFFF, 1'b1, '{NO_VALUE, ST_RANGE, 7'd5}},
        '{ACT_AT,     7'd127, 32'h1234_5678, 1'b1, '{NO_VALUE, ST_RANGE, 7'd5}},
        '{ACT_DELETE, 7'd5,   32'h0000_0000, 1'b1, '{NO_VALUE, ST_RANGE, 7'd5}},
        '{ACT_DELETE, 7'd64,  32'h0000_0000, 1'b1, '{NO_VALUE, ST_RANGE, 7'd5}},
        '{ACT_DELETE, 7'd2,   32'h0000_0000, 1'b0, '0},
        '{ACT_DELETE, 7'd0,   32'h0000_0000, 1'b0, '0},
        '{ACT_RSVD5,  7'd0,   32'h0000_0000, 1'b1, '{NO_VALUE, ST_RANGE, 7'd3}},
        '{ACT_RSVD6,  7'd1,   32'h0000_0001, 1'b1, '{NO_VALUE, ST_RANGE, 7'd3}},
        '{ACT_RSVD7,  7'd127, 32'hFFFF_FFFF, 1'b1, '{NO_VALUE, ST_RANGE, 7'd3}},
        '{ACT_READ,   7'd2,   32'h0000_0000, 1'b0, '0},
        '{ACT_TAIL,   7'd0,   32'h2AAA_AAAA, 1'b0, '0}
    };

    indexed_list_store DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_position   (s_position),
        .s_item_value (s_item_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_length_now (m_length_now)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time, pending.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Applies one action to the list and returns the result beat it yields.
    function automatic list_result_t apply_action(input logic [ACT_W-1:0] act,
            input logic [CNT_W-1:0] pos, input logic [DATA_W-1:0] val);
        list_result_t r;
        int           at;
        r.rv = NO_VALUE;
        r.st = ST_DONE;
        at   = int'(pos);
        case (act)
            ACT_READ: begin
                if (at < list_len)
                    r.rv = list_mem[at];
                else
                    r.st = ST_RANGE;
            end
            ACT_HEAD, ACT_TAIL, ACT_AT: begin
                if (act == ACT_HEAD)
                    at = 0;
                else if (act == ACT_TAIL)
                    at = list_len;
                // range check takes priority over full
                if (at > list_len) begin
                    r.st = ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    r.st = ST_FULL;
                end else begin
                    for (int i = list_len; i > at; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[at] = val;
                    list_len++;
                end
            end
            ACT_DELETE: begin
                if (at < list_len) begin
                    for (int i = at; i < list_len - 1; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end else begin
                    r.st = ST_RANGE;
                end
            end
            default: r.st = ST_RANGE;
        endcase
        r.len = CNT_W'(list_len);
        return r;
    endfunction

    task automatic push_item(input logic [ACT_W-1:0] act, input logic [CNT_W-1:0] pos,
            input logic [DATA_W-1:0] val, input logic typed, input list_result_t typed_res);
        list_result_t r;
        int           gap;
        gap = steady ? 0 : pick_idle();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_position   <= pos;
        s_item_value <= val;
        do @(posedge aclk); while (!s_ready);
        r = apply_action(act, pos, val);
        if (typed)
            r = typed_res;
        pending.push_back(r);
        n_items++;
        if (r.st == ST_FULL)
            n_full++;
        if (r.st == ST_RANGE)
            n_range++;
    endtask

    task automatic pick_item(input phase_kind_t kind, output logic [ACT_W-1:0] act,
            output logic [CNT_W-1:0] pos, output logic [DATA_W-1:0] val);
        int ins_pct;
        int del_pct;
        int roll;
        ins_pct = (kind == PH_FILL) ? 75 : (kind == PH_DRAIN) ? 15 : 40;
        del_pct = (kind == PH_FILL) ? 10 : (kind == PH_DRAIN) ? 65 : 30;
        roll    = $urandom_range(0, 99);
        if (roll < 3) begin
            case ($urandom_range(0, 2))
                0:       act = ACT_RSVD5;
                1:       act = ACT_RSVD6;
                default: act = ACT_RSVD7;
            endcase
        end else if (roll < 3 + ins_pct) begin
            case ($urandom_range(0, 2))
                0:       act = ACT_HEAD;
                1:       act = ACT_TAIL;
                default: act = ACT_AT;
            endcase
        end else if (roll < 3 + ins_pct + del_pct) begin
            act = ACT_DELETE;
        end else begin
            act = ACT_READ;
        end

        // mostly legal positions, some anywhere in the field
        if ($urandom_range(0, 99) < 15 || (list_len == 0 && act != ACT_AT))
            pos = CNT_W'($urandom_range(0, 127));
        else if (act == ACT_AT)
            pos = CNT_W'($urandom_range(0, list_len));
        else
            pos = CNT_W'($urandom_range(0, list_len - 1));

        case ($urandom_range(0, 9))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = NO_VALUE;
            3:       val = '0;
            default: val = $urandom;
        endcase
    endtask

    // receiver: stretches of ready and of stall
    always @(posedge aclk) begin
        if (steady) begin
            m_ready    <= 1'b1;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else if (!m_ready) begin
            m_ready    <= 1'b1;
            ready_hold = $urandom_range(1, 8);
        end else begin
            m_ready <= 1'b0;
            case ($urandom_range(0, 19))
                0:         ready_hold = $urandom_range(10, 30);
                1, 2, 3:   ready_hold = $urandom_range(3, 6);
                default:   ready_hold = $urandom_range(0, 1);
            endcase
        end
    end

    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            n_checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat: value %0d status %0d length %0d",
                         $time, m_read_value, m_status, m_length_now);
                mismatches++;
            end else begin
                want = pending.pop_front();
                if (m_read_value !== want.rv) begin
                    $display("%0t: read_value expected %0d got %0d",
                             $time, $signed(want.rv), m_read_value);
                    mismatches++;
                end
                if (m_status !== want.st) begin
                    $display("%0t: status expected %0d got %0d", $time, want.st, m_status);
                    mismatches++;
                end
                if (m_length_now !== want.len) begin
                    $display("%0t: length_now expected %0d got %0d",
                             $time, want.len, m_length_now);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        logic [ACT_W-1:0]  act;
        logic [CNT_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        phase_kind_t       kind;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            push_item(directed_rows[i].act, directed_rows[i].pos, directed_rows[i].val,
                      directed_rows[i].typed, directed_rows[i].res);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph % 3)
                0:       kind = PH_FILL;
                1:       kind = PH_MIXED;
                default: kind = PH_DRAIN;
            endcase
            steady = (ph % 4 == 2);
            // let the pipeline run dry before carrying on
            if (ph == 3 || $urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                while (pending.size() != 0) @(posedge aclk);
            end
            repeat (PHASE_ITEMS) begin
                pick_item(kind, act, pos, val);
                push_item(act, pos, val, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        steady  = 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Ran %0d beats (%0d directed), checked %0d results.",
                 n_items, N_DIRECTED, n_checked);
        $display("Store full hit %0d times, out-of-range status %0d times.", n_full, n_range);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ils_pkg.sv
rtl/core/ils_datapath.sv
rtl/core/ils_controller.sv
rtl/core/indexed_list_store.sv
dv/indexed_list_store_test.sv
